// ===== rtl/sorted_multiset_median_range_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted multiset block
// Concurrent checks sampled on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_MULTISET_MEDIAN_RANGE_ASSERT_SVH
`define SORTED_MULTISET_MEDIAN_RANGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMMR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted multiset: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SMMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted multiset: next-cycle check failed");

`endif

// ===== rtl/smmr_pkg.sv =====
// ----------------------------------------------------------------------------
// smmr_pkg
// Command and status codes and the control bundle sent to the cell chain.
// ----------------------------------------------------------------------------
package smmr_pkg;

    localparam int COUNT_BITS = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_MEDIAN = 2'd2;
    localparam logic [1:0] CMD_RANGE  = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_EMPTY     = 2'd3;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                  cmp_en;
        logic                  ins_en;
        logic                  rem_en;
        logic                  scan_shift;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] mid_lo_idx;
        logic [COUNT_BITS-1:0] mid_hi_idx;
    } cell_ctrl_t;

endpackage

// ===== rtl/smmr_req_if.sv =====
// ----------------------------------------------------------------------------
// smmr_req_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface smmr_req_if #(
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic signed [VALUE_BITS-1:0] operand_value;
    logic signed [VALUE_BITS-1:0] range_low;
    logic signed [VALUE_BITS-1:0] range_high;

    modport source (
        output valid, command, operand_value, range_low, range_high,
        input  ready
    );
    modport sink (
        input  valid, command, operand_value, range_low, range_high,
        output ready
    );
endinterface

// ===== rtl/smmr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// smmr_rsp_if
// Result channel: valid/ready handshake with one result per transaction.
// ----------------------------------------------------------------------------
interface smmr_rsp_if #(
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic signed [VALUE_BITS-1:0] element_value;
    logic                         has_element;
    logic signed [VALUE_BITS:0]   median_value;
    logic [smmr_pkg::COUNT_BITS-1:0] entry_count;
    logic                         is_last;

    modport source (
        output valid, status, element_value, has_element, median_value, entry_count,
               is_last,
        input  ready
    );
    modport sink (
        input  valid, status, element_value, has_element, median_value, entry_count,
               is_last,
        output ready
    );
endinterface

// ===== rtl/sorted_multiset_median_range.sv =====
// Insert, remove and median: the cells compare, then the apply step loads the result
// into the output register once it has room; the next command is taken back in idle.
// Range query: the same steps, then the scan chain moves one cell per cycle, but a match
// at its head waits for room in the output register; results then follow one per cycle.
// Reset clears the entry count and control state; cell values stay undefined, with
// no clearing pass, as only entries below the count are ever read.
// ----------------------------------------------------------------------------
// sorted_multiset_median_range
// Sorted multiset of signed fixed-point values held in a chain of cells, with
// insert, remove, median and ascending range listing.
// ----------------------------------------------------------------------------
module sorted_multiset_median_range #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    smmr_req_if.sink   req,
    smmr_rsp_if.source rsp
);
    localparam int CB = smmr_pkg::COUNT_BITS;
    localparam logic [CB-1:0] CAP_COUNT = CB'(CAPACITY);

    // Controller sequence per command: take the transaction, let every cell
    // compare (flags registered inside the cells), then apply the shift and
    // write the result. A range query then walks the scan chain.
    typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_APPLY, ST_SCAN} state_t;

    state_t                       state_reg;
    logic [1:0]                   cmd_reg;
    logic signed [VALUE_BITS-1:0] operand_reg;
    logic signed [VALUE_BITS-1:0] low_reg;
    logic signed [VALUE_BITS-1:0] high_reg;
    logic [CB-1:0]                count_reg;
    logic [VALUE_BITS-1:0]        pick_lo_reg;
    logic [VALUE_BITS-1:0]        pick_hi_reg;

    logic                         out_valid_reg;
    logic [1:0]                   out_status_reg;
    logic signed [VALUE_BITS-1:0] out_element_reg;
    logic                         out_has_reg;
    logic signed [VALUE_BITS:0]   out_median_reg;
    logic [CB-1:0]                out_count_reg;
    logic                         out_last_reg;

    state_t                       state_next;
    logic [1:0]                   cmd_next;
    logic signed [VALUE_BITS-1:0] operand_next;
    logic signed [VALUE_BITS-1:0] low_next;
    logic signed [VALUE_BITS-1:0] high_next;
    logic [CB-1:0]                count_next;
    logic [VALUE_BITS-1:0]        pick_lo_next;
    logic [VALUE_BITS-1:0]        pick_hi_next;

    logic                         out_valid_next;
    logic [1:0]                   out_status_next;
    logic signed [VALUE_BITS-1:0] out_element_next;
    logic                         out_has_next;
    logic signed [VALUE_BITS:0]   out_median_next;
    logic [CB-1:0]                out_count_next;
    logic                         out_last_next;

    smmr_pkg::cell_ctrl_t ctrl;

    logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic signed [VALUE_BITS-1:0] cell_scan  [CAPACITY];
    logic [VALUE_BITS-1:0]        cell_lo    [CAPACITY];
    logic [VALUE_BITS-1:0]        cell_hi    [CAPACITY];
    logic [CAPACITY-1:0]          ins_vec;
    logic [CAPACITY-1:0]          eq_vec;
    logic [CAPACITY-1:0]          match_vec;

    logic                  full;
    logic                  found;
    logic                  any_match;
    logic                  out_free;
    logic [CB-1:0]         mid_hi_idx;
    logic [VALUE_BITS-1:0] pick_lo_any;
    logic [VALUE_BITS-1:0] pick_hi_any;
    logic signed [VALUE_BITS:0] median_sum;

    assign full      = (count_reg == CAP_COUNT);
    assign found     = |eq_vec;
    assign any_match = |match_vec;
    // The output register may be refilled when empty or when its result leaves now.
    assign out_free  = !out_valid_reg || rsp.ready;

    // Middle index, and the one below it for an even count. An empty set
    // selects nothing useful, but that case reports an empty status anyway.
    assign mid_hi_idx = count_reg >> 1;

    assign ctrl.cmp_en     = (state_reg == ST_CMP);
    assign ctrl.ins_en     = (state_reg == ST_APPLY) && (cmd_reg == smmr_pkg::CMD_INSERT)
                             && !full && out_free;
    assign ctrl.rem_en     = (state_reg == ST_APPLY) && (cmd_reg == smmr_pkg::CMD_REMOVE)
                             && found && out_free;
    // Non-matching cells at the head of the scan chain are skipped regardless
    // of the output side; a match waits for room in the output register.
    assign ctrl.scan_shift = (state_reg == ST_SCAN) && (out_free || !match_vec[0]);
    assign ctrl.count      = count_reg;
    assign ctrl.mid_hi_idx = mid_hi_idx;
    assign ctrl.mid_lo_idx = count_reg[0] ? mid_hi_idx : (mid_hi_idx - 1'b1);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_BITS-1:0] left_value;
        logic                         left_ins;
        logic signed [VALUE_BITS-1:0] right_value;
        logic signed [VALUE_BITS-1:0] right_scan_value;
        logic                         right_scan_match;

        if (i == 0)
        begin : g_head
            assign left_value = '0;
            assign left_ins   = 1'b0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_ins   = ins_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value      = cell_value[i];
            assign right_scan_value = '0;
            assign right_scan_match = 1'b0;
        end
        else
        begin : g_inner
            assign right_value      = cell_value[i+1];
            assign right_scan_value = cell_scan[i+1];
            assign right_scan_match = match_vec[i+1];
        end

        smmr_cell #(
            .INDEX      (i),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk              (clk),
            .rst_n            (rst_n),
            .ctrl             (ctrl),
            .operand          (operand_reg),
            .range_low        (low_reg),
            .range_high       (high_reg),
            .left_value       (left_value),
            .left_ins         (left_ins),
            .right_value      (right_value),
            .right_scan_value (right_scan_value),
            .right_scan_match (right_scan_match),
            .value            (cell_value[i]),
            .ins_flag         (ins_vec[i]),
            .eq_flag          (eq_vec[i]),
            .scan_value       (cell_scan[i]),
            .scan_match       (match_vec[i]),
            .pick_lo          (cell_lo[i]),
            .pick_hi          (cell_hi[i])
        );
    end

    // At most one cell drives a non-zero pick, so an OR gathers the median operands.
    always_comb
    begin
        pick_lo_any = '0;
        pick_hi_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            pick_lo_any = pick_lo_any | cell_lo[i];
            pick_hi_any = pick_hi_any | cell_hi[i];
        end
    end

    // Sum of the two middle values (or twice the single one) is the exact Q8.9 median.
    assign median_sum = $signed({pick_lo_reg[VALUE_BITS-1], pick_lo_reg})
                      + $signed({pick_hi_reg[VALUE_BITS-1], pick_hi_reg});

    // Next-state logic of the controller and the output register. Every field
    // holds its value unless a step below replaces it; a result that is taken
    // by the sink this cycle and not replaced leaves the register empty.
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        operand_next     = operand_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        count_next       = count_reg;
        pick_lo_next     = pick_lo_reg;
        pick_hi_next     = pick_hi_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_element_next = out_element_reg;
        out_has_next     = out_has_reg;
        out_median_next  = out_median_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next     = req.command;
                    operand_next = req.operand_value;
                    low_next     = req.range_low;
                    high_next    = req.range_high;
                    state_next   = ST_CMP;
                end
            end

            ST_CMP:
            begin
                pick_lo_next = pick_lo_any;
                pick_hi_next = pick_hi_any;
                state_next   = ST_APPLY;
            end

            ST_APPLY:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = smmr_pkg::STATUS_OK;
                    out_element_next = '0;
                    out_has_next     = 1'b0;
                    out_median_next  = '0;
                    out_count_next   = count_reg;
                    out_last_next    = 1'b1;
                    state_next       = ST_IDLE;

                    unique case (cmd_reg)
                        smmr_pkg::CMD_INSERT:
                        begin
                            if (full)
                            begin
                                out_status_next = smmr_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                count_next     = count_reg + 1'b1;
                                out_count_next = count_reg + 1'b1;
                            end
                        end

                        smmr_pkg::CMD_REMOVE:
                        begin
                            if (found)
                            begin
                                count_next     = count_reg - 1'b1;
                                out_count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                out_status_next = smmr_pkg::STATUS_NOT_FOUND;
                            end
                        end

                        smmr_pkg::CMD_MEDIAN:
                        begin
                            if (count_reg == '0)
                                out_status_next = smmr_pkg::STATUS_EMPTY;
                            else
                                out_median_next = median_sum;
                        end

                        smmr_pkg::CMD_RANGE:
                        begin
                            if (any_match)
                            begin
                                // Matches start streaming from the scan chain.
                                out_valid_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                            else
                            begin
                                out_status_next = smmr_pkg::STATUS_EMPTY;
                            end
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (match_vec[0] && out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = smmr_pkg::STATUS_OK;
                    out_element_next = cell_scan[0];
                    out_has_next     = 1'b1;
                    out_median_next  = '0;
                    out_count_next   = count_reg;
                    // The set is sorted, so the matches are contiguous: the last
                    // one is the match whose neighbour does not match.
                    out_last_next    = !match_vec[1];
                    if (!match_vec[1])
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= smmr_pkg::CMD_INSERT;
            operand_reg     <= '0;
            low_reg         <= '0;
            high_reg        <= '0;
            count_reg       <= '0;
            pick_lo_reg     <= '0;
            pick_hi_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= smmr_pkg::STATUS_OK;
            out_element_reg <= '0;
            out_has_reg     <= 1'b0;
            out_median_reg  <= '0;
            out_count_reg   <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            operand_reg     <= operand_next;
            low_reg         <= low_next;
            high_reg        <= high_next;
            count_reg       <= count_next;
            pick_lo_reg     <= pick_lo_next;
            pick_hi_reg     <= pick_hi_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_element_reg <= out_element_next;
            out_has_reg     <= out_has_next;
            out_median_reg  <= out_median_next;
            out_count_reg   <= out_count_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.element_value = out_element_reg;
    assign rsp.has_element   = out_has_reg;
    assign rsp.median_value  = out_median_reg;
    assign rsp.entry_count   = out_count_reg;
    assign rsp.is_last       = out_last_reg;

    `include "sorted_multiset_median_range_assert.svh"

    // The stored count never passes the number of cells.
    `SMMR_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CAP_COUNT)
    // A command transaction always moves the controller into the compare step.
    `SMMR_ASSERT_NEXT(a_accept_to_cmp, req.valid && req.ready, state_reg == ST_CMP)
    // A successful remove takes exactly one entry away.
    `SMMR_ASSERT_NEXT(a_remove_count, ctrl.rem_en, count_reg == $past(count_reg) - 1'b1)
    // While scanning, at least one match is still waiting in the chain.
    `SMMR_ASSERT_SAME(a_scan_has_match, state_reg == ST_SCAN, any_match)

endmodule

// ===== rtl/smmr_cell.sv =====
// ----------------------------------------------------------------------------
// smmr_cell
// One slot of the sorted chain: holds a value, compares it against the
// broadcast operand and shifts with its neighbours on insert, remove and scan.
// ----------------------------------------------------------------------------
module smmr_cell #(
    parameter int INDEX      = 0,
    parameter int VALUE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  smmr_pkg::cell_ctrl_t         ctrl,
    input  logic signed [VALUE_BITS-1:0] operand,
    input  logic signed [VALUE_BITS-1:0] range_low,
    input  logic signed [VALUE_BITS-1:0] range_high,
    input  logic signed [VALUE_BITS-1:0] left_value,
    input  logic                         left_ins,
    input  logic signed [VALUE_BITS-1:0] right_value,
    input  logic signed [VALUE_BITS-1:0] right_scan_value,
    input  logic                         right_scan_match,
    output logic signed [VALUE_BITS-1:0] value,
    output logic                         ins_flag,
    output logic                         eq_flag,
    output logic signed [VALUE_BITS-1:0] scan_value,
    output logic                         scan_match,
    output logic [VALUE_BITS-1:0]        pick_lo,
    output logic [VALUE_BITS-1:0]        pick_hi
);
    localparam logic [smmr_pkg::COUNT_BITS-1:0] IDX = smmr_pkg::COUNT_BITS'(INDEX);

    logic signed [VALUE_BITS-1:0] value_reg;
    logic signed [VALUE_BITS-1:0] scan_value_reg;
    logic                         ins_reg;
    logic                         rem_reg;
    logic                         eq_reg;
    logic                         scan_match_reg;

    logic occupied;
    logic ins_next;
    logic rem_next;
    logic eq_next;
    logic match_next;

    assign occupied   = IDX < ctrl.count;
    // The new value lands before the first entry strictly greater, or at the end.
    assign ins_next   = occupied ? (value_reg > operand) : (IDX == ctrl.count);
    assign rem_next   = occupied && (value_reg >= operand);
    assign eq_next    = occupied && (value_reg == operand);
    assign match_next = occupied && (value_reg >= range_low) && (value_reg <= range_high);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_reg        <= 1'b0;
            rem_reg        <= 1'b0;
            eq_reg         <= 1'b0;
            scan_match_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            ins_reg        <= ins_next;
            rem_reg        <= rem_next;
            eq_reg         <= eq_next;
            scan_match_reg <= match_next;
        end
        else if (ctrl.scan_shift)
        begin
            scan_match_reg <= right_scan_match;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en)
        begin
            if (left_ins)
                value_reg <= left_value;
            else if (ins_reg)
                value_reg <= operand;
        end
        else if (ctrl.rem_en && rem_reg)
        begin
            value_reg <= right_value;
        end

        if (ctrl.cmp_en)
            scan_value_reg <= value_reg;
        else if (ctrl.scan_shift)
            scan_value_reg <= right_scan_value;
    end

    assign value      = value_reg;
    assign ins_flag   = ins_reg;
    assign eq_flag    = eq_reg;
    assign scan_value = scan_value_reg;
    assign scan_match = scan_match_reg;
    assign pick_lo    = (IDX == ctrl.mid_lo_idx) ? value_reg : '0;
    assign pick_hi    = (IDX == ctrl.mid_hi_idx) ? value_reg : '0;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the sorted multiset with median and range listing
// Commands are sent through a queue-fed driver and every result transaction is
// checked, field by field, against a cycle-free model of the sorted multiset
// that is updated as each command transaction is accepted.
// ----------------------------------------------------------------------------
module tb;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 16;
    localparam int IDLE_PCT   = 11;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = 16'sh8000;
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = 16'sh7FFF;

    // One command as it is driven onto the request channel.
    typedef struct {
        logic [1:0]                   command;
        logic signed [VALUE_BITS-1:0] operand_value;
        logic signed [VALUE_BITS-1:0] range_low;
        logic signed [VALUE_BITS-1:0] range_high;
    } command_item_t;

    // One result transaction as the multiset should produce it.
    typedef struct {
        logic [1:0]                      status;
        logic signed [VALUE_BITS-1:0]    element_value;
        logic                            has_element;
        logic signed [VALUE_BITS:0]      median_value;
        logic [smmr_pkg::COUNT_BITS-1:0] entry_count;
        logic                            is_last;
    } result_item_t;

    logic clk;
    logic rst_n;

    // When set, neither side of the design inserts idle cycles.
    logic steady;

    smmr_req_if #(.VALUE_BITS(VALUE_BITS)) cmd_ch ();
    smmr_rsp_if #(.VALUE_BITS(VALUE_BITS)) res_ch ();

    sorted_multiset_median_range #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmd_ch),
        .rsp   (res_ch)
    );

    // Commands waiting to be driven, and results still owed by the design.
    command_item_t pending_cmds[$];
    result_item_t  expected_results[$];

    // Our own copy of the multiset: ascending values and how many are held.
    logic signed [VALUE_BITS-1:0] set_values [CAPACITY];
    int                           set_size;

    // Values that were sent for insertion; removals draw on this so that they
    // usually hit something that is really stored.
    logic signed [VALUE_BITS-1:0] inserted_pool[$];

    int error_count;

    // ------------------------------------------------------------------------
    // Model of the multiset. Called once per accepted command transaction; it
    // updates the local copy and queues every result the command must produce.
    // ------------------------------------------------------------------------
    task automatic predict_command(input logic [1:0] op,
                                   input logic signed [VALUE_BITS-1:0] operand,
                                   input logic signed [VALUE_BITS-1:0] low,
                                   input logic signed [VALUE_BITS-1:0] high);
        result_item_t res;
        int           pos;
        int           idx;
        int           match_total;
        int           emitted;
        int           median_sum;

        res.status        = smmr_pkg::STATUS_OK;
        res.element_value = '0;
        res.has_element   = 1'b0;
        res.median_value  = '0;
        res.is_last       = 1'b1;

        case (op)
            smmr_pkg::CMD_INSERT:
            begin
                if (set_size >= CAPACITY)
                    res.status = smmr_pkg::STATUS_FULL;
                else
                begin
                    // A new value goes after any entries equal to it.
                    pos = 0;
                    while (pos < set_size && set_values[pos] <= operand)
                        pos++;
                    for (idx = set_size; idx > pos; idx--)
                        set_values[idx] = set_values[idx - 1];
                    set_values[pos] = operand;
                    set_size++;
                end
            end
            smmr_pkg::CMD_REMOVE:
            begin
                pos = 0;
                while (pos < set_size && set_values[pos] != operand)
                    pos++;
                if (pos >= set_size)
                    res.status = smmr_pkg::STATUS_NOT_FOUND;
                else
                begin
                    for (idx = pos; idx + 1 < set_size; idx++)
                        set_values[idx] = set_values[idx + 1];
                    set_size--;
                end
            end
            smmr_pkg::CMD_MEDIAN:
            begin
                if (set_size == 0)
                    res.status = smmr_pkg::STATUS_EMPTY;
                else
                begin
                    // The result is in Q8.9, so twice the Q8.8 median: exact,
                    // with neither rounding nor saturation.
                    if (set_size % 2 == 1)
                        median_sum = 2 * int'(set_values[set_size / 2]);
                    else
                        median_sum = int'(set_values[set_size / 2 - 1])
                                   + int'(set_values[set_size / 2]);
                    res.median_value = median_sum[VALUE_BITS:0];
                end
            end
            default:
            begin
                match_total = 0;
                for (idx = 0; idx < set_size; idx++)
                    if (set_values[idx] >= low && set_values[idx] <= high)
                        match_total++;
                if (match_total == 0)
                    res.status = smmr_pkg::STATUS_EMPTY;
                else
                begin
                    // One result per match in ascending order; the last one
                    // carries is_last.
                    emitted = 0;
                    res.has_element = 1'b1;
                    res.entry_count = set_size[smmr_pkg::COUNT_BITS-1:0];
                    for (idx = 0; idx < set_size; idx++)
                    begin
                        if (set_values[idx] >= low && set_values[idx] <= high)
                        begin
                            emitted++;
                            res.element_value = set_values[idx];
                            res.is_last       = (emitted == match_total);
                            expected_results  = {expected_results, res};
                        end
                    end
                    return;
                end
            end
        endcase

        res.entry_count  = set_size[smmr_pkg::COUNT_BITS-1:0];
        expected_results = {expected_results, res};
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_command(input logic [1:0] op,
                                 input logic signed [VALUE_BITS-1:0] operand,
                                 input logic signed [VALUE_BITS-1:0] low,
                                 input logic signed [VALUE_BITS-1:0] high);
        command_item_t item;
        item.command       = op;
        item.operand_value = operand;
        item.range_low     = low;
        item.range_high    = high;
        pending_cmds       = {pending_cmds, item};
    endtask

    // Whole and half steps around zero, so that duplicates turn up often.
    function automatic logic signed [VALUE_BITS-1:0] palette_value();
        int steps;
        steps = $urandom_range(0, 31) - 16;
        return VALUE_BITS'(steps * 128);
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        int choice;
        choice = $urandom_range(0, 3);
        if (choice < 2 && inserted_pool.size() != 0)
            return inserted_pool[$urandom_range(0, inserted_pool.size() - 1)];
        else if (choice == 2)
            return palette_value();
        return VALUE_BITS'($urandom);
    endfunction

    // Builds one random command; the mix of operations is given in percent,
    // with range queries taking what is left.
    function automatic command_item_t random_command(input int insert_pct,
                                                     input int remove_pct,
                                                     input int median_pct);
        command_item_t                item;
        int                           roll;
        int                           slot;
        int                           upper;
        logic signed [VALUE_BITS-1:0] swap_value;

        item.operand_value = VALUE_BITS'($urandom);
        item.range_low     = VALUE_BITS'($urandom);
        item.range_high    = VALUE_BITS'($urandom);

        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
        begin
            item.command = smmr_pkg::CMD_INSERT;
            if ($urandom_range(0, 9) < 4)
                item.operand_value = palette_value();
            inserted_pool = {inserted_pool, item.operand_value};
        end
        else if (roll < insert_pct + remove_pct)
        begin
            item.command = smmr_pkg::CMD_REMOVE;
            if (inserted_pool.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                slot = $urandom_range(0, inserted_pool.size() - 1);
                item.operand_value = inserted_pool[slot];
                inserted_pool.delete(slot);
            end
            else
                item.operand_value = pick_value();
        end
        else if (roll < insert_pct + remove_pct + median_pct)
            item.command = smmr_pkg::CMD_MEDIAN;
        else
        begin
            item.command = smmr_pkg::CMD_RANGE;
            case ($urandom_range(0, 9))
                0, 1:
                    ; // both bounds fully random, often the wrong way round
                2, 3, 4, 5:
                begin
                    item.range_low  = pick_value();
                    item.range_high = pick_value();
                    if (item.range_low > item.range_high)
                    begin
                        swap_value      = item.range_low;
                        item.range_low  = item.range_high;
                        item.range_high = swap_value;
                    end
                end
                6:
                begin
                    item.range_low  = VALUE_MIN;
                    item.range_high = VALUE_MAX;
                end
                default:
                begin
                    item.range_low = pick_value();
                    upper = int'(item.range_low) + $urandom_range(0, 512);
                    if (upper > int'(VALUE_MAX))
                        upper = int'(VALUE_MAX);
                    item.range_high = VALUE_BITS'(upper);
                end
            endcase
        end
        return item;
    endfunction

    task automatic queue_random_phase(input int count, input int insert_pct,
                                      input int remove_pct, input int median_pct);
        repeat (count)
            pending_cmds = {pending_cmds,
                            random_command(insert_pct, remove_pct, median_pct)};
    endtask

    // Holds the stimulus back until every command has been taken and every
    // result it owes has come back.
    task automatic wait_until_quiet();
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        $error("tb: %s mismatch, expected %0d, got %0d", field, want, got);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset. The driver and the result side take their idle values
    // from the reset branches of their own blocks.
    // ------------------------------------------------------------------------
    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Command driver. A transaction completes at an edge where valid and ready
    // are both high; the model is updated there, with the values that were on
    // the bus. A new command is only presented once the old one has gone, and
    // valid is written once per edge, so it drops between two commands only when the driver idles.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_commands
        command_item_t upcoming;
        if (!rst_n)
        begin
            cmd_ch.valid         <= 1'b0;
            cmd_ch.command       <= smmr_pkg::CMD_INSERT;
            cmd_ch.operand_value <= '0;
            cmd_ch.range_low     <= '0;
            cmd_ch.range_high    <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                predict_command(cmd_ch.command, cmd_ch.operand_value,
                                cmd_ch.range_low, cmd_ch.range_high);
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (pending_cmds.size() != 0
                    && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    upcoming = pending_cmds.pop_front();
                    cmd_ch.valid         <= 1'b1;
                    cmd_ch.command       <= upcoming.command;
                    cmd_ch.operand_value <= upcoming.operand_value;
                    cmd_ch.range_low     <= upcoming.range_low;
                    cmd_ch.range_high    <= upcoming.range_high;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // The result side stalls at random, apart from the steady stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Result monitor: every result transaction is matched against the oldest
    // expectation. Any result that arrives with nothing owed is an error.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        result_item_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("tb: result transaction arrived with nothing outstanding");
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch("status", want.status, res_ch.status);
                if (res_ch.element_value !== want.element_value)
                    report_mismatch("element_value", want.element_value,
                                    res_ch.element_value);
                if (res_ch.has_element !== want.has_element)
                    report_mismatch("has_element", want.has_element, res_ch.has_element);
                if (res_ch.median_value !== want.median_value)
                    report_mismatch("median_value", want.median_value,
                                    res_ch.median_value);
                if (res_ch.entry_count !== want.entry_count)
                    report_mismatch("entry_count", want.entry_count, res_ch.entry_count);
                if (res_ch.is_last !== want.is_last)
                    report_mismatch("is_last", want.is_last, res_ch.is_last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        error_count = 0;
        set_size    = 0;
        steady      = 1'b0;

        // Directed part: the empty set, the extreme values, duplicates, the
        // even and odd median, a query with its bounds the wrong way round and
        // a removal of something that is not there.
        queue_command(smmr_pkg::CMD_MEDIAN, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_RANGE,  16'sh0000, VALUE_MIN, VALUE_MAX);
        queue_command(smmr_pkg::CMD_REMOVE, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_INSERT, VALUE_MAX, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_MEDIAN, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_INSERT, VALUE_MIN, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_MEDIAN, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_INSERT, VALUE_MIN, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_MEDIAN, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_INSERT, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_INSERT, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_RANGE,  16'sh0000, VALUE_MIN, VALUE_MAX);
        queue_command(smmr_pkg::CMD_RANGE,  16'sh0000, VALUE_MIN, VALUE_MIN);
        queue_command(smmr_pkg::CMD_RANGE,  16'sh0000, 16'sh0001, 16'sh0000);
        queue_command(smmr_pkg::CMD_RANGE,  16'sh0000, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_REMOVE, 16'sh1234, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_REMOVE, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_REMOVE, VALUE_MIN, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_REMOVE, VALUE_MAX, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_RANGE,  16'sh0000, 16'sh0001, 16'sh0100);
        queue_command(smmr_pkg::CMD_MEDIAN, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_INSERT, 16'sh0180, 16'sh0000, 16'sh0000);
        queue_command(smmr_pkg::CMD_MEDIAN, 16'sh0000, 16'sh0000, 16'sh0000);

        // Let the directed commands finish completely before carrying on.
        wait_until_quiet();

        // Mostly insertions, so that the set fills up, becomes full and then
        // drops values; queries against a full set give the longest bursts.
        queue_random_phase(90, 90, 3, 3);
        wait_until_quiet();

        // A stretch with neither side idling, on a well-mixed load.
        steady <= 1'b1;
        queue_random_phase(60, 35, 30, 15);
        while (pending_cmds.size() != 0)
            @(posedge clk);
        steady <= 1'b0;

        // Mostly removals, draining the set again.
        queue_random_phase(107, 15, 55, 15);

        // Every command has been handed over; wait for the last results, then
        // give the design time to show any stray extra transaction.
        wait_until_quiet();
        repeat (CAPACITY + 8) @(posedge clk);

        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
